### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// clocked on aclk; the first form is gated by the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define PCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define PCD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`endif

### hw/rtl/pcd_pkg.sv
// types, register codes and averaging helpers for the corner decimator
// no dependencies
`default_nettype none
package pcd_pkg;

    // one point as it travels on the stream, x in the lowest bits
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic        z_ok;
        logic        y_ok;
        logic        x_ok;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
    } point_t;

    localparam int POINT_W = $bits(point_t);
    localparam int DATA_W  = 128;
    localparam int CFG_W   = 11;
    localparam int CNT_W   = 10;

    // four corners of one block, ready for averaging
    typedef struct packed {
        logic   last;
        point_t br;
        point_t ll;
        point_t tr;
        point_t tl;
    } job_t;

    typedef struct packed {
        logic [10:0] frame_width;
        logic [10:0] frame_height;
        logic [4:0]  block_w;
        logic [4:0]  block_h;
    } cfg_t;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BLOCK_W      = 2'd2;
    localparam logic [1:0] REG_BLOCK_H      = 2'd3;

    // floor of the signed four-way sum over four
    function automatic logic [31:0] avg4_coord(input logic [31:0] a, input logic [31:0] b,
                                               input logic [31:0] c, input logic [31:0] d);
        logic [33:0] s;
        s = {{2{a[31]}}, a} + {{2{b[31]}}, b} + {{2{c[31]}}, c} + {{2{d[31]}}, d};
        return s[33:2];
    endfunction

    function automatic logic [7:0] avg4_color(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] d);
        logic [9:0] s;
        s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d};
        return s[9:2];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/pcd_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module pcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/pcd_front.sv
// front end: raster position tracking, corner classification, top-corner line store
// depends on pcd_pkg and pcd_ram
`default_nettype none
module pcd_front #(
    parameter int MAX_BLOCKS_PER_ROW = 512
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire pcd_pkg::cfg_t cfg,
    input  wire logic          cfg_clear,
    input  wire logic          in_accept,
    input  wire pcd_pkg::point_t in_point,
    output logic               job_valid,
    output pcd_pkg::job_t      job
);
    import pcd_pkg::*;

    localparam int AW = (MAX_BLOCKS_PER_ROW > 1) ? $clog2(MAX_BLOCKS_PER_ROW) : 1;

    logic [CNT_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [CNT_W-1:0] bx_reg, bx_next;
    logic [4:0]       px_reg, px_next, py_reg, py_next;
    logic [10:0]      bsx_reg, bsx_next, bsy_reg, bsy_next;
    logic [11:0]      bx_end, by_end;
    logic             in_x, in_y, last_x, last_y, px_left, px_right, py_top, py_bot;
    logic             col_wrap, row_wrap, bx_in_ram;
    logic             wr_left, wr_right, rd_go, ll_load;
    logic             e1_valid_reg, e1_ram_ok_reg, e1_last_reg;
    point_t           e1_br_reg, e1_ll_reg, ll_reg;
    point_t           left_rd, right_rd;
    logic [AW-1:0]    addr;

    assign bx_end   = {1'b0, bsx_reg} + {7'd0, cfg.block_w};
    assign by_end   = {1'b0, bsy_reg} + {7'd0, cfg.block_h};
    assign in_x     = bx_end <= {1'b0, cfg.frame_width};
    assign in_y     = by_end <= {1'b0, cfg.frame_height};
    assign last_x   = (bx_end + {7'd0, cfg.block_w}) > {1'b0, cfg.frame_width};
    assign last_y   = (by_end + {7'd0, cfg.block_h}) > {1'b0, cfg.frame_height};
    assign px_left  = px_reg == 5'd0;
    assign px_right = px_reg == (cfg.block_w - 5'd1);
    assign py_top   = py_reg == 5'd0;
    assign py_bot   = py_reg == (cfg.block_h - 5'd1);
    assign col_wrap = ({1'b0, col_reg} + 11'd1) >= cfg.frame_width;
    assign row_wrap = ({1'b0, row_reg} + 11'd1) >= cfg.frame_height;
    assign bx_in_ram = 32'(bx_reg) < MAX_BLOCKS_PER_ROW;
    assign addr     = AW'(bx_reg);

    assign wr_left  = in_accept && in_x && in_y && py_top && px_left && bx_in_ram;
    assign wr_right = in_accept && in_x && in_y && py_top && px_right && bx_in_ram;
    assign ll_load  = in_accept && in_x && in_y && !py_top && py_bot && px_left;
    assign rd_go    = in_accept && in_x && in_y && !py_top && py_bot && px_right;

    // raster position with block-relative offsets, no division needed
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        px_next  = px_reg;
        py_next  = py_reg;
        bx_next  = bx_reg;
        bsx_next = bsx_reg;
        bsy_next = bsy_reg;
        if (cfg_clear) begin
            col_next = '0;
            row_next = '0;
            px_next  = '0;
            py_next  = '0;
            bx_next  = '0;
            bsx_next = '0;
            bsy_next = '0;
        end else if (in_accept) begin
            if (col_wrap) begin
                col_next = '0;
                px_next  = '0;
                bx_next  = '0;
                bsx_next = '0;
                if (row_wrap) begin
                    row_next = '0;
                    py_next  = '0;
                    bsy_next = '0;
                end else begin
                    row_next = row_reg + 10'd1;
                    if (py_bot) begin
                        py_next  = '0;
                        bsy_next = bsy_reg + {6'd0, cfg.block_h};
                    end else begin
                        py_next = py_reg + 5'd1;
                    end
                end
            end else begin
                col_next = col_reg + 10'd1;
                if (px_right) begin
                    px_next  = '0;
                    bx_next  = bx_reg + 10'd1;
                    bsx_next = bsx_reg + {6'd0, cfg.block_w};
                end else begin
                    px_next = px_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            px_reg       <= '0;
            py_reg       <= '0;
            bx_reg       <= '0;
            bsx_reg      <= '0;
            bsy_reg      <= '0;
            e1_valid_reg <= 1'b0;
            ll_reg       <= '0;
        end else begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            px_reg       <= px_next;
            py_reg       <= py_next;
            bx_reg       <= bx_next;
            bsx_reg      <= bsx_next;
            bsy_reg      <= bsy_next;
            e1_valid_reg <= rd_go;
            if (ll_load) begin
                ll_reg <= in_point;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_go) begin
            e1_br_reg     <= in_point;
            e1_ll_reg     <= ll_reg;
            e1_ram_ok_reg <= bx_in_ram;
            e1_last_reg   <= last_x && last_y;
        end
    end

    pcd_ram #(.WIDTH(POINT_W), .DEPTH(MAX_BLOCKS_PER_ROW)) u_left_store (
        .aclk    (aclk),
        .wr_en   (wr_left),
        .wr_addr (addr),
        .wr_data (in_point),
        .rd_en   (rd_go),
        .rd_addr (addr),
        .rd_data (left_rd)
    );

    pcd_ram #(.WIDTH(POINT_W), .DEPTH(MAX_BLOCKS_PER_ROW)) u_right_store (
        .aclk    (aclk),
        .wr_en   (wr_right),
        .wr_addr (addr),
        .wr_data (in_point),
        .rd_en   (rd_go),
        .rd_addr (addr),
        .rd_data (right_rd)
    );

    assign job_valid = e1_valid_reg;
    assign job.tl    = e1_ram_ok_reg ? left_rd : '0;
    assign job.tr    = e1_ram_ok_reg ? right_rd : '0;
    assign job.ll    = e1_ll_reg;
    assign job.br    = e1_br_reg;
    assign job.last  = e1_last_reg;
endmodule
`default_nettype wire

### hw/rtl/pcd_queue.sv
// short job queue between front and back end
// depends on pcd_pkg
`default_nettype none
module pcd_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire pcd_pkg::job_t              push_job,
    input  wire logic                       pop,
    output logic                            head_valid,
    output pcd_pkg::job_t                   head_job,
    output logic [$clog2(DEPTH+1)-1:0]      count
);
    import pcd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];
    assign count      = count_reg;
endmodule
`default_nettype wire

### hw/rtl/pcd_back.sv
// back end: four-corner averaging into the output register
// depends on pcd_pkg
`default_nettype none
module pcd_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            job_valid,
    input  wire pcd_pkg::job_t   job,
    output logic                 job_pop,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output pcd_pkg::point_t      out_point,
    output logic                 out_last
);
    import pcd_pkg::*;

    point_t avg;
    logic   out_valid_reg;
    point_t out_point_reg;
    logic   out_last_reg;

    always_comb begin
        avg.x_ok  = job.tl.x_ok & job.tr.x_ok & job.ll.x_ok & job.br.x_ok;
        avg.y_ok  = job.tl.y_ok & job.tr.y_ok & job.ll.y_ok & job.br.y_ok;
        avg.z_ok  = job.tl.z_ok & job.tr.z_ok & job.ll.z_ok & job.br.z_ok;
        avg.x     = avg.x_ok ? avg4_coord(job.tl.x, job.tr.x, job.ll.x, job.br.x) : '0;
        avg.y     = avg.y_ok ? avg4_coord(job.tl.y, job.tr.y, job.ll.y, job.br.y) : '0;
        avg.z     = avg.z_ok ? avg4_coord(job.tl.z, job.tr.z, job.ll.z, job.br.z) : '0;
        avg.red   = avg4_color(job.tl.red, job.tr.red, job.ll.red, job.br.red);
        avg.green = avg4_color(job.tl.green, job.tr.green, job.ll.green, job.br.green);
        avg.blue  = avg4_color(job.tl.blue, job.tr.blue, job.ll.blue, job.br.blue);
    end

    assign job_pop = job_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (job_pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            out_point_reg <= avg;
            out_last_reg  <= job.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_point = out_point_reg;
    assign out_last  = out_last_reg;
endmodule
`default_nettype wire

### hw/rtl/point_cloud_corner_decimator_core.sv
// top level of the point cloud corner decimator: config registers and front/queue/back
// depends on pcd_pkg, pcd_front, pcd_queue, pcd_back
//
// Points enter on s_axis in raster order, one per transfer. Each block_w by
// block_h block yields one averaged point on m_axis when its bottom-right
// corner arrives; m_axis_tlast marks the last block of the frame.
// Registers are written through cfg_wr_en/cfg_addr/cfg_wdata while the
// stream is idle; values saturate to their legal range (block sizes from
// their low five bits) and any write restarts the frame at the top left.
// Throughput is one point per cycle while s_axis_tready is high. After its
// corner point is accepted, a result passes through the registered line
// store read and the job queue into the output register. When m_axis
// stalls, results gather in a four-entry queue and s_axis_tready falls once
// the queue plus the job in flight fill it.
// Reset (aresetn low, synchronous) restores 640x480 with 3x3 blocks and
// empties the pipeline; the line store is not cleared.
`default_nettype none
module point_cloud_corner_decimator_core #(
    parameter int MAX_BLOCKS_PER_ROW = 512
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [1:0]                 cfg_addr,
    input  wire logic [pcd_pkg::CFG_W-1:0]  cfg_wdata,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // point_x, point_y, point_z, x_ok, y_ok, z_ok, red_in, green_in, blue_in, zero pad
    input  wire logic [pcd_pkg::DATA_W-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // avg_x, avg_y, avg_z, avg_x_ok, avg_y_ok, avg_z_ok, red_out, green_out, blue_out, zero pad
    output logic [pcd_pkg::DATA_W-1:0]      m_axis_tdata,
    output logic                            m_axis_tlast
);
    import pcd_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QCW    = $clog2(QDEPTH + 1);

    cfg_t          cfg_reg;
    logic [10:0]   dim_sat;
    logic [4:0]    stride_sat;
    logic          in_accept, job_valid, q_valid, q_pop;
    job_t          job, q_job;
    point_t        out_point;
    logic [QCW-1:0] q_count;

    // saturate to [2,1024], and the low five bits to [2,16]
    assign dim_sat    = (cfg_wdata < 11'd2) ? 11'd2 :
                        (cfg_wdata > 11'd1024) ? 11'd1024 : cfg_wdata;
    assign stride_sat = (cfg_wdata[4:0] < 5'd2) ? 5'd2 :
                        (cfg_wdata[4:0] > 5'd16) ? 5'd16 : cfg_wdata[4:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= 11'd640;
            cfg_reg.frame_height <= 11'd480;
            cfg_reg.block_w      <= 5'd3;
            cfg_reg.block_h      <= 5'd3;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= dim_sat;
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= dim_sat;
                REG_BLOCK_W:      cfg_reg.block_w      <= stride_sat;
                REG_BLOCK_H:      cfg_reg.block_h      <= stride_sat;
                default:          cfg_reg.frame_width  <= cfg_reg.frame_width;
            endcase
        end
    end

    // leave room for the job already in flight
    assign s_axis_tready = (32'(q_count) + 32'(job_valid)) < QDEPTH;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    pcd_front #(.MAX_BLOCKS_PER_ROW(MAX_BLOCKS_PER_ROW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cfg_clear (cfg_wr_en),
        .in_accept (in_accept),
        .in_point  (s_axis_tdata[POINT_W-1:0]),
        .job_valid (job_valid),
        .job       (job)
    );

    pcd_queue #(.DEPTH(QDEPTH)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (job_valid),
        .push_job   (job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_job),
        .count      (q_count)
    );

    pcd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_valid),
        .job       (q_job),
        .job_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_point (out_point),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {(DATA_W - POINT_W)'(0), out_point};
endmodule
`default_nettype wire

### hw/rtl/pcd_checker.sv
// port-level checks for the corner decimator, bound to the top level
// depends on assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module pcd_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata,
    input wire logic         m_axis_tlast
);
    `PCD_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
    `PCD_ASSERT(a_hold_data, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "data moved")
    `PCD_ASSERT(a_nan_x_zero, m_axis_tvalid && !m_axis_tdata[96] |-> m_axis_tdata[31:0] == 32'd0, "x not zero")
    `PCD_ASSERT(a_nan_z_zero, m_axis_tvalid && !m_axis_tdata[98] |-> m_axis_tdata[95:64] == 32'd0, "z not zero")
    `PCD_ASSERT_RST(a_reset_idle, !aresetn |=> !m_axis_tvalid, "valid after reset")
endmodule

bind point_cloud_corner_decimator_core pcd_checker u_pcd_checker (.*);
`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench for point_cloud_corner_decimator_core
// depends on pcd_pkg and the core; block corner averages are predicted in-bench
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import pcd_pkg::*;

    localparam int LIMIT = 600000;

    typedef struct packed {
        logic   last;
        point_t pt;
    } block_avg_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [1:0]          cfg_addr = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;

    point_t     points_q[$];
    block_avg_t block_avgs_q[$];
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    int         hold_cycles = 0;
    int         errors = 0;
    int         cycles = 0;
    int         points_sent = 0;
    int         blocks_seen = 0;
    int         frames_seen = 0;

    // predictor state
    logic [32:0] top_x[1024];
    logic [32:0] top_y[1024];
    logic [32:0] top_z[1024];
    logic [23:0] top_rgb[1024];
    logic [32:0] ll_x, ll_y, ll_z;
    logic [23:0] ll_rgb;
    int          col, row, width, height, sx, sy;

    point_cloud_corner_decimator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [CFG_W-1:0] value);
        case (idx)
            REG_FRAME_WIDTH:  width  = clip(int'(value), 2, 1024);
            REG_FRAME_HEIGHT: height = clip(int'(value), 2, 1024);
            REG_BLOCK_W:      sx     = clip(int'(value[4:0]), 2, 16);
            REG_BLOCK_H:      sy     = clip(int'(value[4:0]), 2, 16);
            default: ;
        endcase
        col = 0;
        row = 0;
    endfunction

    // floor of the four-way mean; zero unless all four corners are valid
    function automatic logic [32:0] mean_coord(logic [32:0] a, logic [32:0] b,
                                               logic [32:0] c, logic [32:0] d);
        longint s;
        logic   ok;
        s = longint'($signed(a[31:0])) + longint'($signed(b[31:0]))
          + longint'($signed(c[31:0])) + longint'($signed(d[31:0]));
        s = s >>> 2;
        ok = a[32] & b[32] & c[32] & d[32];
        return {ok, ok ? s[31:0] : 32'd0};
    endfunction

    function automatic logic [7:0] mean_byte(logic [7:0] a, logic [7:0] b,
                                             logic [7:0] c, logic [7:0] d);
        logic [9:0] s;
        s = 10'(a) + 10'(b) + 10'(c) + 10'(d);
        return s[9:2];
    endfunction

    function automatic void decimate_point(point_t p);
        int          bx, px, by, py, nbx, nby, li;
        logic [32:0] cx, cy, cz, mx, my, mz;
        logic [23:0] cc;
        block_avg_t  r;
        bx = col / sx; px = col % sx;
        by = row / sy; py = row % sy;
        nbx = width / sx; nby = height / sy;
        cx = {p.x_ok, p.x}; cy = {p.y_ok, p.y}; cz = {p.z_ok, p.z};
        cc = {p.blue, p.green, p.red};
        li = 2 * bx;
        if (bx < nbx && by < nby && (px == 0 || px == sx - 1)) begin
            if (py == 0) begin
                top_x[li + (px ? 1 : 0)] = cx;
                top_y[li + (px ? 1 : 0)] = cy;
                top_z[li + (px ? 1 : 0)] = cz;
                top_rgb[li + (px ? 1 : 0)] = cc;
            end else if (py == sy - 1) begin
                if (px == 0) begin
                    ll_x = cx; ll_y = cy; ll_z = cz; ll_rgb = cc;
                end else begin
                    mx = mean_coord(top_x[li], top_x[li + 1], ll_x, cx);
                    my = mean_coord(top_y[li], top_y[li + 1], ll_y, cy);
                    mz = mean_coord(top_z[li], top_z[li + 1], ll_z, cz);
                    r.pt = '0;
                    {r.pt.x_ok, r.pt.x} = mx;
                    {r.pt.y_ok, r.pt.y} = my;
                    {r.pt.z_ok, r.pt.z} = mz;
                    r.pt.red = mean_byte(top_rgb[li][7:0], top_rgb[li + 1][7:0],
                                         ll_rgb[7:0], cc[7:0]);
                    r.pt.green = mean_byte(top_rgb[li][15:8], top_rgb[li + 1][15:8],
                                           ll_rgb[15:8], cc[15:8]);
                    r.pt.blue = mean_byte(top_rgb[li][23:16], top_rgb[li + 1][23:16],
                                          ll_rgb[23:16], cc[23:16]);
                    r.last = (bx == nbx - 1 && by == nby - 1);
                    block_avgs_q = {block_avgs_q, r};
                end
            end
        end
        col++;
        if (col >= width) begin
            col = 0;
            row++;
            if (row >= height) row = 0;
        end
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                decimate_point(point_t'(s_axis_tdata[POINT_W-1:0]));
                points_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (points_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tdata <= DATA_W'(points_q.pop_front());
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge aclk) begin
        point_t     got;
        block_avg_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99) >= rx_stall_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got = point_t'(m_axis_tdata[POINT_W-1:0]);
                blocks_seen++;
                if (m_axis_tlast) frames_seen++;
                if (block_avgs_q.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    want = block_avgs_q.pop_front();
                    if (got.x !== want.pt.x) begin
                        $error("avg_x exp %h got %h", want.pt.x, got.x); errors++;
                    end
                    if (got.y !== want.pt.y) begin
                        $error("avg_y exp %h got %h", want.pt.y, got.y); errors++;
                    end
                    if (got.z !== want.pt.z) begin
                        $error("avg_z exp %h got %h", want.pt.z, got.z); errors++;
                    end
                    if (got.x_ok !== want.pt.x_ok) begin
                        $error("avg_x_ok exp %b got %b", want.pt.x_ok, got.x_ok); errors++;
                    end
                    if (got.y_ok !== want.pt.y_ok) begin
                        $error("avg_y_ok exp %b got %b", want.pt.y_ok, got.y_ok); errors++;
                    end
                    if (got.z_ok !== want.pt.z_ok) begin
                        $error("avg_z_ok exp %b got %b", want.pt.z_ok, got.z_ok); errors++;
                    end
                    if (got.red !== want.pt.red) begin
                        $error("red_out exp %h got %h", want.pt.red, got.red); errors++;
                    end
                    if (got.green !== want.pt.green) begin
                        $error("green_out exp %h got %h", want.pt.green, got.green); errors++;
                    end
                    if (got.blue !== want.pt.blue) begin
                        $error("blue_out exp %h got %h", want.pt.blue, got.blue); errors++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("frame_done exp %b got %b", want.last, m_axis_tlast); errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.x = rand_coord(); p.y = rand_coord(); p.z = rand_coord();
        p.x_ok = $urandom_range(99) < 85;
        p.y_ok = $urandom_range(99) < 85;
        p.z_ok = $urandom_range(99) < 85;
        p.red = rand_byte(); p.green = rand_byte(); p.blue = rand_byte();
        return p;
    endfunction

    function automatic point_t fixed_point(logic [31:0] c, logic ok, logic [7:0] b);
        point_t p;
        p.x = c; p.y = c; p.z = c;
        p.x_ok = ok; p.y_ok = 1'b1; p.z_ok = ok;
        p.red = b; p.green = b; p.blue = b;
        return p;
    endfunction

    function automatic void queue_point(point_t p);
        points_q = {points_q, p};
    endfunction

    task automatic drain();
        while (points_q.size() != 0 || s_axis_tvalid || block_avgs_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(value);
        apply_reg(idx, CFG_W'(value));
    endtask

    task automatic set_frame(int w, int h, int bw, int bh);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_BLOCK_W, bw);
        write_reg(REG_BLOCK_H, bh);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_random(int n);
        repeat (n) queue_point(rand_point());
    endtask

    initial begin
        int phase;
        int rand_points;
        int w, h, n;
        width = 640; height = 480; sx = 3; sy = 3; col = 0; row = 0;
        ll_x = '0; ll_y = '0; ll_z = '0; ll_rgb = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: 4x2 frame of 2x2 blocks, extremes, NaN, wrap into next frame
        set_frame(4, 2, 2, 2);
        for (int i = 0; i < 4; i++) queue_point(fixed_point(32'h7FFF_FFFF, 1'b1, 8'hFF));
        for (int i = 0; i < 4; i++) queue_point(fixed_point(32'h8000_0000, 1'b1, 8'hFF));
        queue_point(fixed_point(32'h8000_0000, 1'b1, 8'h00));
        queue_point(fixed_point(32'h7FFF_FFFF, 1'b0, 8'h01));
        queue_point(fixed_point(32'hFFFF_FFFF, 1'b1, 8'h03));
        queue_point(fixed_point(32'h0000_0001, 1'b1, 8'hFE));
        queue_point(fixed_point(32'hFFFF_FFFD, 1'b1, 8'h02));
        queue_point(fixed_point(32'h0000_0000, 1'b1, 8'h80));
        queue_point(fixed_point(32'h0000_0001, 1'b1, 8'h7F));
        queue_point(fixed_point(32'h0000_0001, 1'b0, 8'h01));
        // registers below their floor and above their ceiling saturate
        set_frame(0, 0, 0, 0);
        push_random(10);
        set_frame(2047, 2047, 2047, 2047);
        push_random(40);
        // tallest frame partly sent
        set_frame(2, 1024, 2, 2);
        push_random(60);
        // back to the reset-time shape, first row partly sent
        set_frame(640, 480, 3, 3);
        push_random(20);

        // random phases, the first one under a long receiver hold-off
        phase = 0;
        rand_points = 0;
        while (rand_points < 1100) begin
            drain();
            tx_idle_pct  <= (phase % 4 == 1) ? 61 : (phase % 4 == 3) ? 13 : 0;
            rx_stall_pct <= (phase % 4 == 2) ? 61 : (phase % 4 == 3) ? 13 : 0;
            if (phase == 0) begin
                set_frame(16, 16, 2, 2);
                @(posedge aclk);
                hold_cycles <= 400;
                n = 256;
            end else begin
                w = $urandom_range(2, 20);
                h = $urandom_range(2, 16);
                set_frame(w, h, $urandom_range(2, (w < 6) ? 2 + w % 4 : 6),
                          $urandom_range(2, (h < 6) ? 2 + h % 4 : 6));
                n = w * h * $urandom_range(1, 3);
                if ($urandom_range(3) == 0) n += $urandom_range(1, w * h);
            end
            push_random(n);
            rand_points += n;
            phase++;
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("sent %0d points over %0d random phases, checked %0d block averages",
                 points_sent, phase, blocks_seen);
        $display("%0d frame ends seen, receiver hold-off and saturated registers included",
                 frames_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
+incdir+hw/rtl
hw/rtl/pcd_pkg.sv
hw/rtl/pcd_ram.sv
hw/rtl/pcd_front.sv
hw/rtl/pcd_queue.sv
hw/rtl/pcd_back.sv
hw/rtl/point_cloud_corner_decimator_core.sv
hw/rtl/pcd_checker.sv
tb/sv/testbench.sv
